// File: rtl/enus_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the e-paper tag upload sequencer.
// No dependencies; imported by every module of the block.
package enus_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLOCK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_IMAGE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_TYPE       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT      = 8'd3;

  // Fixed field widths
  localparam int unsigned OFFSET_W = 18;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned DELAY_W  = 10;

  // Reply bytes
  localparam logic [7:0] REPLY_LEN   = 8'd2;
  localparam logic [7:0] REPLY_OK    = 8'h00;
  localparam logic [7:0] REPLY_READY = 8'hFF;

  // Event kinds
  localparam logic EV_READY = 1'b0;
  localparam logic EV_ERROR = 1'b1;

  // Actions
  localparam logic [1:0] ACT_CONTINUE = 2'd0;
  localparam logic [1:0] ACT_RESELECT = 2'd1;
  localparam logic [1:0] ACT_STOP     = 2'd2;

  // Notifications
  localparam logic [2:0] NTF_NONE     = 3'd0;
  localparam logic [2:0] NTF_DETECTED = 3'd1;
  localparam logic [2:0] NTF_BLOCK    = 3'd2;
  localparam logic [2:0] NTF_UPDATING = 3'd3;
  localparam logic [2:0] NTF_DONE     = 3'd4;
  localparam logic [2:0] NTF_WR_ERROR = 3'd5;

  // Host delays in ms
  localparam logic [DELAY_W-1:0] DLY_NONE    = 10'd0;
  localparam logic [DELAY_W-1:0] DLY_BLOCK   = 10'd10;
  localparam logic [DELAY_W-1:0] DLY_POWER   = 10'd200;
  localparam logic [DELAY_W-1:0] DLY_REFRESH = 10'd500;
  localparam logic [DELAY_W-1:0] DLY_POLL    = 10'd100;
  localparam logic [DELAY_W-1:0] DLY_RESTART = 10'd1000;

  // Frame codes
  localparam logic [3:0] FR_SELECT    = 4'd1;
  localparam logic [3:0] FR_DATA      = 4'd8;
  localparam logic [3:0] FR_WAIT      = 4'd11;
  localparam logic [3:0] FR_POWER_OFF = 4'd12;
  localparam logic [3:0] FR_NONE      = 4'd13;

  // Upload phases, one-hot
  typedef enum logic [14:0] {
    PH_INIT      = 15'b000_0000_0000_0001,
    PH_SELECT    = 15'b000_0000_0000_0010,
    PH_NORMAL    = 15'b000_0000_0000_0100,
    PH_CONFIG1   = 15'b000_0000_0000_1000,
    PH_POWER_ON  = 15'b000_0000_0001_0000,
    PH_CONFIG2   = 15'b000_0000_0010_0000,
    PH_LOAD      = 15'b000_0000_0100_0000,
    PH_PREPARE   = 15'b000_0000_1000_0000,
    PH_BLOCK     = 15'b000_0001_0000_0000,
    PH_POWER_V2  = 15'b000_0010_0000_0000,
    PH_REFRESH   = 15'b000_0100_0000_0000,
    PH_WAIT      = 15'b000_1000_0000_0000,
    PH_RESTART   = 15'b001_0000_0000_0000,
    PH_POWER_OFF = 15'b010_0000_0000_0000,
    PH_ERROR     = 15'b100_0000_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]  bytes_per_block;
    logic [10:0] blocks_per_image;
    logic [7:0]  panel_type;
    logic [2:0]  retry_limit;
  } cfg_t;

  // Decoded reply of one poller event
  typedef struct packed {
    logic poll_err;
    logic good;
    logic ready_good;
  } reply_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [3:0]          phase_now;
    logic [3:0]          next_frame;
    logic [7:0]          frame_argument;
    logic                wait_bounded;
    logic [OFFSET_W-1:0] image_offset;
    logic [COUNT_W-1:0]  blocks_done;
    logic [2:0]          notify;
    logic [DELAY_W-1:0]  delay_ms;
  } result_t;

  function automatic logic [3:0] phase_code(phase_e ph);
    logic [3:0] code;
    unique case (ph)
      PH_INIT:      code = 4'd0;
      PH_SELECT:    code = 4'd1;
      PH_NORMAL:    code = 4'd2;
      PH_CONFIG1:   code = 4'd3;
      PH_POWER_ON:  code = 4'd4;
      PH_CONFIG2:   code = 4'd5;
      PH_LOAD:      code = 4'd6;
      PH_PREPARE:   code = 4'd7;
      PH_BLOCK:     code = 4'd8;
      PH_POWER_V2:  code = 4'd9;
      PH_REFRESH:   code = 4'd10;
      PH_WAIT:      code = 4'd11;
      PH_RESTART:   code = 4'd12;
      PH_POWER_OFF: code = 4'd13;
      default:      code = 4'd14;
    endcase
    return code;
  endfunction

  // Frame sent in a phase: same number up to wait ready, then power off frame
  function automatic logic [3:0] frame_of(phase_e ph);
    logic [3:0] code;
    code = phase_code(ph);
    if (code <= FR_WAIT) begin
      return code;
    end else if (ph == PH_POWER_OFF) begin
      return FR_POWER_OFF;
    end
    return FR_NONE;
  endfunction

endpackage

// File: rtl/enus_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the upload sequencer.
// Depends on enus_pkg for the register indexes and cfg_t.
module enus_cfg_regs
  import enus_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_BYTES_PER_BLOCK:  cfg_d.bytes_per_block  = wr_data_i[7:0];
        REG_BLOCKS_PER_IMAGE: cfg_d.blocks_per_image = wr_data_i[10:0];
        REG_PANEL_TYPE:       cfg_d.panel_type       = wr_data_i[7:0];
        REG_RETRY_LIMIT:      cfg_d.retry_limit      = wr_data_i[2:0];
        default:              cfg_d = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_block  <= 8'd16;
      cfg_q.blocks_per_image <= 11'd1;
      cfg_q.panel_type       <= 8'd0;
      cfg_q.retry_limit      <= 3'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/enus_reply_check.sv
`timescale 1ns / 1ps
// Input register of the upload sequencer: takes one poller event per request
// and holds its decoded reply check. Depends on enus_pkg for reply_t.
module enus_reply_check
  import enus_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       event_kind_i,
  input  logic       exchange_ok_i,
  input  logic [7:0] response_length_i,
  input  logic [7:0] response_byte0_i,
  input  logic [7:0] response_byte1_i,
  input  logic       take_i,
  output logic       rep_valid_o,
  output reply_t     rep_o
);

  logic   valid_q, valid_d;
  logic   load;
  logic   base;
  reply_t rep_q, rep_d;

  // Free when empty or when the held request moves on this cycle
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;

  assign base = exchange_ok_i && (response_length_i == REPLY_LEN)
                && (response_byte1_i == REPLY_OK);

  always_comb begin
    rep_d.poll_err   = (event_kind_i == EV_ERROR);
    rep_d.good       = base && (response_byte0_i == REPLY_OK
                                || response_byte0_i == REPLY_READY);
    rep_d.ready_good = base && (response_byte0_i == REPLY_READY);
    valid_d          = load ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      rep_q <= rep_d;
    end
  end

  assign rep_valid_o = valid_q;
  assign rep_o       = rep_q;

endmodule

// File: rtl/enus_phase_fsm.sv
`timescale 1ns / 1ps
// Phase sequencer and result register of the upload sequencer: one decoded event
// per cycle, unless stalled, updates phase, counters, offset. Depends on enus_pkg.
module enus_phase_fsm
  import enus_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    rep_valid_i,
  input  reply_t  rep_i,
  output logic    take_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;

  phase_e              phase_q, phase_d;
  logic [2:0]          restart_q, restart_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       count_inc;
  logic [XW-1:0]       count_ext;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic                step;
  logic                last_block;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          action;
  logic [2:0]          notify;
  logic [DELAY_W-1:0]  delay;
  logic [3:0]          frame;
  result_t             res_q, res_d;

  assign take_o = !out_valid_q || !out_stall_i;
  assign step   = rep_valid_i && take_o;

  assign count_inc  = count_q + CW'(1);
  assign last_block = (XW'(count_inc) == XW'(cfg_i.blocks_per_image))
                      || (count_inc == CW'(MAX_BLOCKS));

  always_comb begin
    phase_d   = phase_q;
    restart_d = restart_q;
    count_d   = count_q;
    offset_d  = offset_q;
    action    = ACT_CONTINUE;
    notify    = NTF_NONE;
    delay     = DLY_NONE;
    if (rep_i.poll_err) begin
      action = ACT_RESELECT;
    end else begin
      unique case (phase_q)
        PH_INIT: begin
          if (rep_i.good) begin
            notify  = NTF_DETECTED;
            phase_d = PH_SELECT;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SELECT:   phase_d = rep_i.good ? PH_NORMAL   : PH_ERROR;
        PH_NORMAL:   phase_d = rep_i.good ? PH_CONFIG1  : PH_ERROR;
        PH_CONFIG1:  phase_d = rep_i.good ? PH_POWER_ON : PH_ERROR;
        PH_POWER_ON: phase_d = rep_i.good ? PH_CONFIG2  : PH_ERROR;
        PH_CONFIG2:  phase_d = rep_i.good ? PH_LOAD     : PH_ERROR;
        PH_LOAD:     phase_d = rep_i.good ? PH_PREPARE  : PH_ERROR;
        PH_PREPARE:  phase_d = rep_i.good ? PH_BLOCK    : PH_ERROR;
        PH_BLOCK: begin
          delay = DLY_BLOCK;
          if (rep_i.good) begin
            offset_d = offset_q + OFFSET_W'(cfg_i.bytes_per_block);
            count_d  = count_inc;
            notify   = NTF_BLOCK;
            if (last_block) begin
              phase_d = PH_POWER_V2;
            end
          end else begin
            phase_d = PH_RESTART;
          end
        end
        PH_POWER_V2: begin
          if (rep_i.good) begin
            phase_d = PH_REFRESH;
            notify  = NTF_UPDATING;
            delay   = DLY_POWER;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_REFRESH: begin
          phase_d = rep_i.good ? PH_WAIT : PH_ERROR;
          delay   = DLY_REFRESH;
        end
        PH_WAIT: begin
          // Keep polling until the panel reports ready
          if (rep_i.ready_good) begin
            phase_d = PH_POWER_OFF;
          end else begin
            delay = DLY_POLL;
          end
        end
        PH_RESTART: begin
          if (restart_q < cfg_i.retry_limit) begin
            restart_d = restart_q + 3'd1;
            phase_d   = PH_INIT;
            offset_d  = '0;
            count_d   = '0;
            delay     = DLY_RESTART;
            action    = ACT_RESELECT;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_POWER_OFF: begin
          if (rep_i.good) begin
            notify = NTF_DONE;
            action = ACT_STOP;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        default: begin
          phase_d = PH_ERROR;
          notify  = NTF_WR_ERROR;
          action  = ACT_STOP;
        end
      endcase
    end

    frame     = (action == ACT_STOP) ? FR_NONE : frame_of(phase_d);
    count_ext = XW'(count_d);

    res_d.action         = action;
    res_d.phase_now      = phase_code(phase_d);
    res_d.next_frame     = frame;
    res_d.frame_argument = (frame == FR_SELECT) ? cfg_i.panel_type      :
                           (frame == FR_DATA)   ? cfg_i.bytes_per_block : 8'd0;
    res_d.wait_bounded   = (frame == FR_DATA) || (frame == FR_WAIT);
    res_d.image_offset   = offset_d;
    res_d.blocks_done    = count_ext[COUNT_W-1:0];
    res_d.notify         = notify;
    res_d.delay_ms       = delay;

    out_valid_d = step ? 1'b1 : (take_o ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INIT;
      restart_q   <= 3'd0;
      count_q     <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        phase_q   <= phase_d;
        restart_q <= restart_d;
        count_q   <= count_d;
        offset_q  <= offset_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("left the error phase");

  a_restart_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_q != $past(restart_q) |->
      restart_q == $past(restart_q) + 3'd1 && phase_q == PH_INIT)
    else $error("restart count moved without a restart to init");

  a_stop_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.action == ACT_STOP |->
      res_q.next_frame == FR_NONE && !res_q.wait_bounded
      && res_q.frame_argument == 8'd0)
    else $error("stop result carries a frame");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !rep_i.poll_err && phase_q == PH_RESTART
      && restart_q < cfg_i.retry_limit |=> count_q == '0 && offset_q == '0)
    else $error("restart did not clear the upload position");
`endif

endmodule

// File: rtl/eink_nfc_upload_sequencer.sv
`timescale 1ns / 1ps
// Upload sequencer for an NFC e-paper tag. Each request is one poller event;
// the block answers with exactly one result (next frame, argument, image offset,
// action, notification, host delay), in order. A request goes through an input
// register and the phase update into a result register, so a result is valid
// once its request has passed the input register, and one request is taken every
// cycle while results are not stalled; the phase, counter and offset update is the
// single step between the two registers. The input side keeps accepting while a
// result waits to be taken, until both registers are full. Registers are written
// via the always ready config port; the user must write them only while no
// request is in flight (not enforced by the block); unknown indexes are dropped.
// Depends on enus_pkg, enus_cfg_regs, enus_reply_check and enus_phase_fsm.
module eink_nfc_upload_sequencer
  import enus_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Poller events
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  event_kind_i,
  input  logic                  exchange_ok_i,
  input  logic [7:0]            response_length_i,
  input  logic [7:0]            response_byte0_i,
  input  logic [7:0]            response_byte1_i,
  // Results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            action_o,
  output logic [3:0]            phase_now_o,
  output logic [3:0]            next_frame_o,
  output logic [7:0]            frame_argument_o,
  output logic                  wait_bounded_o,
  output logic [OFFSET_W-1:0]   image_offset_o,
  output logic [COUNT_W-1:0]    blocks_done_o,
  output logic [2:0]            notify_o,
  output logic [DELAY_W-1:0]    delay_ms_o,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  reply_t  rep;
  logic    rep_valid;
  logic    take;
  result_t res;

  assign cfg_ready_o = 1'b1;

  enus_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  enus_reply_check u_reply (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .event_kind_i      (event_kind_i),
    .exchange_ok_i     (exchange_ok_i),
    .response_length_i (response_length_i),
    .response_byte0_i  (response_byte0_i),
    .response_byte1_i  (response_byte1_i),
    .take_i            (take),
    .rep_valid_o       (rep_valid),
    .rep_o             (rep)
  );

  enus_phase_fsm #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .rep_valid_i (rep_valid),
    .rep_i       (rep),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign action_o         = res.action;
  assign phase_now_o      = res.phase_now;
  assign next_frame_o     = res.next_frame;
  assign frame_argument_o = res.frame_argument;
  assign wait_bounded_o   = res.wait_bounded;
  assign image_offset_o   = res.image_offset;
  assign blocks_done_o    = res.blocks_done;
  assign notify_o         = res.notify;
  assign delay_ms_o       = res.delay_ms;

endmodule

// File: tb/sv/enus_upload_checker.sv
`timescale 1ns / 1ps
// Result checker for the e-paper tag upload sequencer: tracks register writes,
// predicts one result per accepted request and compares results in order.
// Depends on enus_pkg.
module enus_upload_checker
  import enus_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  event_kind_i,
  input  logic                  exchange_ok_i,
  input  logic [7:0]            response_length_i,
  input  logic [7:0]            response_byte0_i,
  input  logic [7:0]            response_byte1_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            action_i,
  input  logic [3:0]            phase_now_i,
  input  logic [3:0]            next_frame_i,
  input  logic [7:0]            frame_argument_i,
  input  logic                  wait_bounded_i,
  input  logic [OFFSET_W-1:0]   image_offset_i,
  input  logic [COUNT_W-1:0]    blocks_done_i,
  input  logic [2:0]            notify_i,
  input  logic [DELAY_W-1:0]    delay_ms_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           waiting_o
);

  localparam int unsigned PRINT_CAP = 50;
  localparam cfg_t CFG_AT_RESET = '{
    bytes_per_block: 8'd16, blocks_per_image: 11'd1, panel_type: 8'd0,
    retry_limit: 3'd5
  };

  // Phase numbering as reported on phase_now
  typedef enum logic [3:0] {
    ST_INIT, ST_SELECT, ST_NORMAL, ST_CONFIG1, ST_POWER_ON, ST_CONFIG2, ST_LOAD,
    ST_PREPARE, ST_BLOCK, ST_POWER_V2, ST_REFRESH, ST_WAIT, ST_RESTART,
    ST_POWER_OFF, ST_ERROR
  } stage_e;

  stage_e              stage;
  logic [2:0]          restarts;
  logic [COUNT_W-1:0]  blocks;
  logic [OFFSET_W-1:0] offset;
  cfg_t                regs;

  result_t             expected_q[$];
  result_t             want;
  result_t             next_result;
  int unsigned         fail_total = 0;
  int unsigned         results_seen = 0;

  assign mismatches_o = fail_total;

  task automatic report(input string what);
    fail_total++;
    if (fail_total <= PRINT_CAP) begin
      $display("MISMATCH %s", what);
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      report($sformatf("result %0d %s: expected %0d, got %0d",
                       results_seen, field, exp_val, got_val));
    end
  endtask

  // Advance the upload by one poller event and build its result
  task automatic advance_upload(output result_t r);
    logic               base;
    logic               good;
    logic               ready_good;
    logic [1:0]         act;
    logic [2:0]         ntf;
    logic [DELAY_W-1:0] dly;
    logic [3:0]         frm;
    base = exchange_ok_i && response_length_i == REPLY_LEN && response_byte1_i == 8'h00;
    good = base && (response_byte0_i == REPLY_OK || response_byte0_i == REPLY_READY);
    ready_good = base && response_byte0_i == REPLY_READY;
    act = ACT_CONTINUE;
    ntf = NTF_NONE;
    dly = DLY_NONE;

    if (event_kind_i == EV_ERROR) begin
      act = ACT_RESELECT;
    end else if (stage < ST_BLOCK) begin
      if (good) begin
        if (stage == ST_INIT) ntf = NTF_DETECTED;
        stage = stage_e'(stage + 4'd1);
      end else begin
        stage = ST_ERROR;
      end
    end else begin
      case (stage)
        ST_BLOCK: begin
          dly = DLY_BLOCK;
          if (good) begin
            offset = offset + OFFSET_W'(regs.bytes_per_block);
            blocks = blocks + COUNT_W'(1);
            if (blocks == regs.blocks_per_image || blocks >= MAX_BLOCKS) begin
              stage = ST_POWER_V2;
            end
            ntf = NTF_BLOCK;
          end else begin
            stage = ST_RESTART;
          end
        end
        ST_POWER_V2: begin
          if (good) begin
            stage = ST_REFRESH;
            ntf = NTF_UPDATING;
            dly = DLY_POWER;
          end else begin
            stage = ST_ERROR;
          end
        end
        ST_REFRESH: begin
          stage = good ? ST_WAIT : ST_ERROR;
          dly = DLY_REFRESH;
        end
        ST_WAIT: begin
          if (ready_good) stage = ST_POWER_OFF;
          else dly = DLY_POLL;
        end
        ST_RESTART: begin
          // start the whole upload over while restarts remain
          if (restarts < regs.retry_limit) begin
            restarts = restarts + 3'd1;
            stage = ST_INIT;
            offset = '0;
            blocks = '0;
            dly = DLY_RESTART;
            act = ACT_RESELECT;
          end else begin
            stage = ST_ERROR;
          end
        end
        ST_POWER_OFF: begin
          if (good) begin
            ntf = NTF_DONE;
            act = ACT_STOP;
          end else begin
            stage = ST_ERROR;
          end
        end
        default: begin
          stage = ST_ERROR;
          ntf = NTF_WR_ERROR;
          act = ACT_STOP;
        end
      endcase
    end

    if (act == ACT_STOP) frm = FR_NONE;
    else if (stage <= ST_WAIT) frm = stage;
    else if (stage == ST_POWER_OFF) frm = FR_POWER_OFF;
    else frm = FR_NONE;

    r.action = act;
    r.phase_now = stage;
    r.next_frame = frm;
    r.frame_argument = (frm == FR_SELECT) ? regs.panel_type :
                       (frm == FR_DATA) ? regs.bytes_per_block : 8'h00;
    r.wait_bounded = (frm == FR_DATA || frm == FR_WAIT);
    r.image_offset = offset;
    r.blocks_done = blocks;
    r.notify = ntf;
    r.delay_ms = dly;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage = ST_INIT;
      restarts = '0;
      blocks = '0;
      offset = '0;
      regs = CFG_AT_RESET;
      expected_q.delete();
      waiting_o <= 0;
    end else begin
      // check before queueing, so a stray result cannot match this edge's request
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report($sformatf("result %0d arrived with no request waiting", results_seen));
        end else begin
          want = expected_q.pop_front();
          compare_field("action", 32'(want.action), 32'(action_i));
          compare_field("phase_now", 32'(want.phase_now), 32'(phase_now_i));
          compare_field("next_frame", 32'(want.next_frame), 32'(next_frame_i));
          compare_field("frame_argument", 32'(want.frame_argument),
                        32'(frame_argument_i));
          compare_field("wait_bounded", 32'(want.wait_bounded), 32'(wait_bounded_i));
          compare_field("image_offset", 32'(want.image_offset), 32'(image_offset_i));
          compare_field("blocks_done", 32'(want.blocks_done), 32'(blocks_done_i));
          compare_field("notify", 32'(want.notify), 32'(notify_i));
          compare_field("delay_ms", 32'(want.delay_ms), 32'(delay_ms_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BYTES_PER_BLOCK:  regs.bytes_per_block = cfg_data_i[7:0];
          REG_BLOCKS_PER_IMAGE: regs.blocks_per_image = cfg_data_i[10:0];
          REG_PANEL_TYPE:       regs.panel_type = cfg_data_i[7:0];
          REG_RETRY_LIMIT:      regs.retry_limit = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        advance_upload(next_result);
        expected_q.push_back(next_result);
      end
      waiting_o <= expected_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the e-paper tag upload sequencer: clock, reset, poller
// event requests, register writes, result stalls and the verdict.
// Depends on enus_pkg, eink_nfc_upload_sequencer and enus_upload_checker.
module tb_top;
  import enus_pkg::*;

  localparam int unsigned MAX_BLOCKS    = 1024;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned NOISE_PCT     = 6;
  localparam int unsigned SETUP_STEPS   = 8;
  localparam int unsigned BLOCK_BUDGET  = 1100;
  localparam int unsigned RESTART_RUNS  = 6;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  event_kind = EV_READY;
  logic                  exchange_ok = 1'b0;
  logic [7:0]            response_length = 8'h00;
  logic [7:0]            response_byte0 = 8'h00;
  logic [7:0]            response_byte1 = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            action;
  logic [3:0]            phase_now;
  logic [3:0]            next_frame;
  logic [7:0]            frame_argument;
  logic                  wait_bounded;
  logic [OFFSET_W-1:0]   image_offset;
  logic [COUNT_W-1:0]    blocks_done;
  logic [2:0]            notify;
  logic [DELAY_W-1:0]    delay_ms;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned           mismatches;
  int unsigned           waiting;
  int unsigned           idle_run = 0;
  bit                    quiet = 1'b0;

  eink_nfc_upload_sequencer #(.MAX_BLOCKS(MAX_BLOCKS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .event_kind_i(event_kind), .exchange_ok_i(exchange_ok),
    .response_length_i(response_length),
    .response_byte0_i(response_byte0), .response_byte1_i(response_byte1),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .action_o(action), .phase_now_o(phase_now), .next_frame_o(next_frame),
    .frame_argument_o(frame_argument), .wait_bounded_o(wait_bounded),
    .image_offset_o(image_offset), .blocks_done_o(blocks_done),
    .notify_o(notify), .delay_ms_o(delay_ms),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  enus_upload_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .event_kind_i(event_kind), .exchange_ok_i(exchange_ok),
    .response_length_i(response_length),
    .response_byte0_i(response_byte0), .response_byte1_i(response_byte1),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .action_i(action), .phase_now_i(phase_now), .next_frame_i(next_frame),
    .frame_argument_i(frame_argument), .wait_bounded_i(wait_bounded),
    .image_offset_i(image_offset), .blocks_done_i(blocks_done),
    .notify_i(notify), .delay_ms_i(delay_ms),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .waiting_o(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] pick_ok_byte();
    return $urandom_range(0, 1) ? REPLY_READY : REPLY_OK;
  endfunction

  // Present one request and hold it until taken
  task automatic send_event(input logic kind, input logic xok, input logic [7:0] len,
                            input logic [7:0] b0, input logic [7:0] b1);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    event_kind <= kind;
    exchange_ok <= xok;
    response_length <= len;
    response_byte0 <= b0;
    response_byte1 <= b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_good(input logic [7:0] b0);
    send_event(EV_READY, 1'b1, REPLY_LEN, b0, 8'h00);
  endtask

  // Reply that fails the check, mostly one field off from a good one
  task automatic send_bad();
    logic       xok;
    logic [7:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    xok = 1'b1;
    len = REPLY_LEN;
    b0 = pick_ok_byte();
    b1 = 8'h00;
    case ($urandom_range(0, 4))
      0: xok = 1'b0;
      1: do len = 8'($urandom_range(0, 255)); while (len == REPLY_LEN);
      2: b1 = 8'($urandom_range(1, 255));
      3: do b0 = 8'($urandom_range(0, 255)); while (b0 == REPLY_OK || b0 == REPLY_READY);
      default: begin
        xok = 1'($urandom_range(0, 1));
        len = 8'($urandom_range(0, 255));
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        if (len == REPLY_LEN && b1 == 8'h00 && (b0 == REPLY_OK || b0 == REPLY_READY)) begin
          xok = 1'b0;
        end
      end
    endcase
    send_event(EV_READY, xok, len, b0, b1);
  endtask

  task automatic send_noise();
    send_event(EV_ERROR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_any_ready();
    send_event(EV_READY, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < NOISE_PCT) send_noise();
  endtask

  task automatic step_good();
    maybe_noise();
    send_good(pick_ok_byte());
  endtask

  // Hold requests until every result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper data bits are random; an unknown index is written first
  task automatic apply_settings(input logic [7:0] bsize, input logic [10:0] btotal,
                                input logic [7:0] stype, input logic [2:0] retries);
    write_reg(CFG_IDX_W'($urandom_range(REG_RETRY_LIMIT + 1, 255)),
              CFG_DATA_W'($urandom_range(0, 2047)));
    write_reg(REG_BYTES_PER_BLOCK, {3'($urandom_range(0, 7)), bsize});
    write_reg(REG_BLOCKS_PER_IMAGE, btotal);
    write_reg(REG_PANEL_TYPE, {3'($urandom_range(0, 7)), stype});
    write_reg(REG_RETRY_LIMIT, {8'($urandom_range(0, 255)), retries});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    phase_e      fail_at;
    int unsigned early_idx;
    int unsigned final_blocks;
    int unsigned avg;
    int unsigned k;
    logic [10:0] final_total;
    logic [10:0] btotal;
    logic [7:0]  bsize;
    logic [7:0]  stype;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, one pass up to a failed block write and restart
    send_noise();
    send_good(REPLY_OK);
    for (int i = 1; i < SETUP_STEPS; i++) begin
      send_good((i % 2) ? REPLY_READY : REPLY_OK);
    end
    drain();
    send_noise();
    send_event(EV_READY, 1'b0, REPLY_LEN, REPLY_OK, 8'h00);
    send_noise();
    send_any_ready();

    // Plan how the last upload ends; it is terminal, so only one ending per run
    early_idx = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: fail_at = PH_POWER_OFF;
      5: fail_at = PH_BLOCK;
      6: fail_at = PH_POWER_V2;
      7: fail_at = PH_REFRESH;
      default: begin
        early_idx = $urandom_range(0, SETUP_STEPS - 1);
        fail_at = phase_e'(15'(1) << early_idx);
      end
    endcase
    if (fail_at == PH_BLOCK) begin
      final_total = '0;
      final_blocks = $urandom_range(300, 1000);
    end else if (fail_at > PH_BLOCK) begin
      case ($urandom_range(0, 4))
        0: final_total = 11'd1;
        1: final_total = 11'(MAX_BLOCKS);
        2: final_total = 11'd0;
        3: final_total = 11'd2047;
        default: final_total = 11'($urandom_range(1, MAX_BLOCKS));
      endcase
      final_blocks = (final_total == 0 || final_total > MAX_BLOCKS) ? MAX_BLOCKS : final_total;
    end else begin
      final_total = 11'($urandom_range(0, 2047));
      final_blocks = 0;
    end
    avg = (final_blocks < BLOCK_BUDGET) ? (BLOCK_BUDGET - final_blocks) / RESTART_RUNS : 0;

    // Uploads that end in a failed block write and a restart
    for (int p = 1; p <= RESTART_RUNS; p++) begin
      k = $urandom_range(0, 2 * avg);
      if (p == 3) k = k + 40;
      case (p)
        1: btotal = 11'(MAX_BLOCKS);
        2: btotal = 11'd0;
        4: btotal = 11'd2047;
        default: btotal = 11'($urandom_range(k + 1, 2047));
      endcase
      bsize = (p == 1) ? 8'd1 : (p == 2) ? 8'd255 : 8'($urandom_range(1, 255));
      stype = (p == 1) ? 8'd255 : (p == 2) ? 8'd0 : 8'($urandom_range(0, 255));
      drain();
      apply_settings(bsize, btotal, stype, 3'($urandom_range(p + 1, 7)));
      quiet = (p == 3);
      repeat (SETUP_STEPS) step_good();
      repeat (k) step_good();
      maybe_noise();
      send_bad();
      maybe_noise();
      send_any_ready();
    end
    quiet = 1'b0;

    // Last upload, with no restarts left
    drain();
    case ($urandom_range(0, 3))
      0: bsize = 8'd1;
      1: bsize = 8'd255;
      default: bsize = 8'($urandom_range(1, 255));
    endcase
    apply_settings(bsize, final_total, 8'($urandom_range(0, 255)), 3'd0);
    if (fail_at < PH_BLOCK) begin
      repeat (early_idx) step_good();
      maybe_noise();
      send_bad();
    end else begin
      repeat (SETUP_STEPS) step_good();
      repeat (final_blocks) step_good();
      if (fail_at == PH_BLOCK) begin
        send_bad();
        send_any_ready();
      end else if (fail_at == PH_POWER_V2) begin
        send_bad();
      end else begin
        step_good();
        if (fail_at == PH_REFRESH) begin
          send_bad();
        end else begin
          step_good();
          // poll with anything but a ready reply, then the ready reply
          repeat ($urandom_range(0, 6)) begin
            maybe_noise();
            if ($urandom_range(0, 1)) send_good(REPLY_OK);
            else send_bad();
          end
          maybe_noise();
          send_good(REPLY_READY);
          repeat ($urandom_range(1, 3)) step_good();
          send_bad();
        end
      end
    end
    repeat ($urandom_range(4, 10)) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_any_ready();
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/enus_pkg.sv
rtl/enus_cfg_regs.sv
rtl/enus_reply_check.sv
rtl/enus_phase_fsm.sv
rtl/eink_nfc_upload_sequencer.sv
tb/sv/enus_upload_checker.sv
tb/sv/tb_top.sv
